[rtl/spfr_pkg.sv]
// Package: shared types, constants and state encoding for the packet framer.
`timescale 1ns / 1ps

package spfr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int PTR_W        = $clog2(BUFFER_BYTES);
    localparam int RLEN_W       = PTR_W + 1;

    localparam logic [5:0]        MAX_PAYLOAD_LEN = 6'(BUFFER_BYTES - 9);
    localparam logic [RLEN_W-1:0] FULL_STORE_LEN  = RLEN_W'(BUFFER_BYTES);

    localparam logic [7:0] START_MARK = 8'hAA;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] LEN_BIAS   = 8'd4;
    localparam logic [2:0] HDR_LAST   = 3'd7;

    localparam logic OP_PAYLOAD = 1'b0;
    localparam logic OP_REPLAY  = 1'b1;

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] cmd_id;
        logic [5:0] payload_len;
        logic [7:0] payload_byte;
        logic       corrupt;
    } spfr_cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic [1:0] status;
    } spfr_frm_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_DATA,
        S_CSUM,
        S_STATUS,
        S_RP_START,
        S_RP_DATA
    } spfr_state_t;

endpackage

[rtl/spfr_ram.sv]
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module spfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sequenced_packet_framer_with_replay.sv]
// Top level: sync/length/checksum packet framer with replay of the last frame.
//
//  channel | signals                      | beat moves
//  --------+------------------------------+------------------------------------
//  cmd     | cmd_valid, cmd_stall, cmd    | payload byte or replay request
//  frm     | frm_valid, frm_stall, frm    | frame byte or status code
//
//  First payload byte of a frame: accept, 8 header bytes, then the data byte, and the
//  checksum too when the payload is one byte; later payload bytes: accept, then the
//  data byte, and the checksum after the last one. Replay of an N-byte frame: accept,
//  store read, N bytes; a status beat: accept, then the status code. One item is
//  worked on at a time; the next is taken once its last beat is loaded into the
//  output register. Stalls on frm simply hold the sequencer.
//  Reset needs no clearing pass: store entries are only read after a frame
//  has written them.
`timescale 1ns / 1ps

module sequenced_packet_framer_with_replay
    import spfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  spfr_cmd_t cmd,
    output logic      frm_valid,
    input  logic      frm_stall,
    output spfr_frm_t frm
);

    spfr_state_t       state_reg, state_next;
    logic [31:0]       seq_reg, seq_next;
    logic              frame_active_reg, frame_active_next;
    logic [5:0]        rem_reg, rem_next;
    logic [7:0]        sum_reg, sum_next;
    logic              corrupt_reg, corrupt_next;
    logic [RLEN_W-1:0] replay_len_reg, replay_len_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [2:0]        hdr_idx_reg, hdr_idx_next;
    logic [PTR_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [1:0]        status_reg, status_next;
    logic [7:0]        data_reg, data_next;
    logic [7:0]        cmd_id_reg, cmd_id_next;

    logic              out_valid_reg;
    spfr_frm_t         out_reg;

    logic              out_free;
    logic              emit;
    logic [7:0]        emit_byte;
    logic              emit_last;
    logic [1:0]        emit_status;

    logic              ram_we;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [7:0]        ram_rdata;

    logic [5:0]        plen_sat;
    logic [5:0]        rem_dec;
    logic [PTR_W-1:0]  ptr_inc;
    logic [PTR_W-1:0]  rd_idx_inc;
    logic              rd_last;
    logic [7:0]        hdr_byte;
    logic [7:0]        seq_byte;

    assign out_free  = !out_valid_reg || !frm_stall;
    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        plen_sat = cmd.payload_len;
        if (plen_sat == 6'd0)
        begin
            plen_sat = 6'd1;
        end
        if (plen_sat > MAX_PAYLOAD_LEN)
        begin
            plen_sat = MAX_PAYLOAD_LEN;
        end
    end

    assign rem_dec    = (rem_reg != 6'd0) ? rem_reg - 6'd1 : rem_reg;
    assign ptr_inc    = ptr_reg + PTR_W'(1);
    assign rd_idx_inc = rd_idx_reg + PTR_W'(1);
    assign rd_last    = ({1'b0, rd_idx_reg} + RLEN_W'(1)) == replay_len_reg;

    // sequence number goes out most significant byte first
    always_comb
    begin
        case (hdr_idx_reg[1:0])
            2'd0:    seq_byte = seq_reg[31:24];
            2'd1:    seq_byte = seq_reg[23:16];
            2'd2:    seq_byte = seq_reg[15:8];
            default: seq_byte = seq_reg[7:0];
        endcase
    end

    always_comb
    begin
        if (hdr_idx_reg[2])
        begin
            hdr_byte = seq_byte;
        end
        else
        begin
            case (hdr_idx_reg[1:0])
                2'd0:    hdr_byte = START_MARK;
                2'd1:    hdr_byte = cmd_id_reg;
                2'd2:    hdr_byte = ZERO_BYTE;   // length never exceeds one byte
                default: hdr_byte = {2'b00, rem_reg} + LEN_BIAS;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        seq_next          = seq_reg;
        frame_active_next = frame_active_reg;
        rem_next          = rem_reg;
        sum_next          = sum_reg;
        corrupt_next      = corrupt_reg;
        replay_len_next   = replay_len_reg;
        ptr_next          = ptr_reg;
        hdr_idx_next      = hdr_idx_reg;
        rd_idx_next       = rd_idx_reg;
        status_next       = status_reg;
        data_next         = data_reg;
        cmd_id_next       = cmd_id_reg;
        emit              = 1'b0;
        emit_byte         = ZERO_BYTE;
        emit_last         = 1'b0;
        emit_status       = ST_BYTE;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = rd_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    data_next = cmd.payload_byte;
                    if (cmd.op == OP_REPLAY)
                    begin
                        if (frame_active_reg)
                        begin
                            status_next = ST_BUSY;
                            state_next  = S_STATUS;
                        end
                        else if (replay_len_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_STATUS;
                        end
                        else
                        begin
                            rd_idx_next = '0;
                            state_next  = S_RP_START;
                        end
                    end
                    else if (!frame_active_reg)
                    begin
                        cmd_id_next       = cmd.cmd_id;
                        rem_next          = plen_sat;
                        corrupt_next      = cmd.corrupt;
                        sum_next          = ZERO_BYTE;
                        ptr_next          = '0;
                        hdr_idx_next      = '0;
                        frame_active_next = 1'b1;
                        state_next        = S_HDR;
                    end
                    else
                    begin
                        state_next = S_DATA;
                    end
                end
            end

            S_HDR:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    emit_byte    = hdr_byte;
                    ram_we       = 1'b1;
                    ptr_next     = ptr_inc;
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                    if (hdr_idx_reg[2])
                    begin
                        sum_next = sum_reg + hdr_byte;
                    end
                    if (hdr_idx_reg == HDR_LAST)
                    begin
                        state_next = S_DATA;
                    end
                end
            end

            S_DATA:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_byte = data_reg;
                    ram_we    = 1'b1;
                    ptr_next  = ptr_inc;
                    sum_next  = sum_reg + data_reg;
                    rem_next  = rem_dec;
                    if (rem_dec == 6'd0)
                    begin
                        state_next = S_CSUM;
                    end
                    else
                    begin
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            S_CSUM:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_byte = corrupt_reg ? ZERO_BYTE : sum_reg;
                    emit_last = 1'b1;
                    ram_we    = 1'b1;
                    ptr_next  = ptr_inc;
                    // a full store wraps the pointer to zero
                    replay_len_next   = (ptr_inc == '0) ? FULL_STORE_LEN : {1'b0, ptr_inc};
                    seq_next          = seq_reg + 32'd1;
                    frame_active_next = 1'b0;
                    sum_next          = ZERO_BYTE;
                    corrupt_next      = 1'b0;
                    state_next        = S_IDLE;
                end
            end

            S_STATUS:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_byte   = ZERO_BYTE;
                    emit_last   = 1'b1;
                    emit_status = status_reg;
                    state_next  = S_IDLE;
                end
            end

            S_RP_START:
            begin
                ram_re     = 1'b1;
                ram_raddr  = rd_idx_reg;
                state_next = S_RP_DATA;
            end

            S_RP_DATA:
            begin
                // read data holds until the next read, so a stall just waits here
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_byte = ram_rdata;
                    if (rd_last)
                    begin
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = rd_idx_inc;
                        rd_idx_next = rd_idx_inc;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            seq_reg          <= 32'd1;
            frame_active_reg <= 1'b0;
            rem_reg          <= 6'd0;
            sum_reg          <= ZERO_BYTE;
            corrupt_reg      <= 1'b0;
            replay_len_reg   <= '0;
            ptr_reg          <= '0;
            hdr_idx_reg      <= 3'd0;
            rd_idx_reg       <= '0;
            status_reg       <= ST_BYTE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            seq_reg          <= seq_next;
            frame_active_reg <= frame_active_next;
            rem_reg          <= rem_next;
            sum_reg          <= sum_next;
            corrupt_reg      <= corrupt_next;
            replay_len_reg   <= replay_len_next;
            ptr_reg          <= ptr_next;
            hdr_idx_reg      <= hdr_idx_next;
            rd_idx_reg       <= rd_idx_next;
            status_reg       <= status_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!frm_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        cmd_id_reg <= cmd_id_next;
        if (emit)
        begin
            out_reg.out_byte    <= emit_byte;
            out_reg.last_of_run <= emit_last;
            out_reg.status      <= emit_status;
        end
    end

    assign frm_valid = out_valid_reg;
    assign frm       = out_reg;

    spfr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (emit_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef ASSERT_OFF
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store written and read in the same cycle");

    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && (frm.status != ST_BYTE) |-> (frm.out_byte == ZERO_BYTE) && frm.last_of_run)
        else $error("status beat carries data or is not last");

    a_replay_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        replay_len_reg <= FULL_STORE_LEN)
        else $error("replay length beyond store size");

    a_replay_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RP_DATA) |-> !frame_active_reg && (replay_len_reg != '0))
        else $error("replay running while a frame is open or nothing stored");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(seq_reg) |-> $past(state_reg == S_CSUM))
        else $error("sequence counter moved outside checksum beat");
`endif

endmodule
